FILE: rtl/core/ssq_pkg.sv
// shared types and constants of the slot stack with overflow queue
`default_nettype none

package ssq_pkg;

  // fixed field widths
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned TAG_W       = 64;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned LOT_USED_W  = 5;
  localparam int unsigned WAIT_USED_W = 4;

  // operation code of an input transfer
  localparam logic FUNC_ARRIVE = 1'b0;

  // result status codes
  typedef enum logic [2:0] {
    ST_PLACED    = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_REJECTED  = 3'd2,
    ST_DEPARTED  = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_LOT_EMPTY = 3'd5
  } status_e;

  // input transfer
  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] car_key;
    logic [TAG_W-1:0] owner_tag;
  } req_t;

  // result transfer
  typedef struct packed {
    status_e                status;
    logic                   promoted;
    logic [LOT_USED_W-1:0]  lot_used;
    logic [WAIT_USED_W-1:0] wait_used;
  } res_t;

  // one stored entry of lot or ring
  typedef struct packed {
    logic [KEY_W-1:0] car_key;
    logic [TAG_W-1:0] owner_tag;
  } entry_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    capture;
    logic    lot_push;
    logic    ring_push;
    logic    scan_start;
    logic    scan_en;
    logic    lot_drop;
    logic    promote;
    logic    finish;
    status_e status;
    logic    promoted;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic func;
    logic lot_room;
    logic ring_full;
    logic lot_empty;
    logic ring_empty;
    logic scan_done;
    logic found;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/slot_stack_with_overflow_queue.sv
// Parking lot stack with overflow waiting ring. An input transfer is taken
// when start_i is high while busy_o is low; its single result appears on
// res_o with done_o, high for exactly one cycle, and the receiver cannot
// hold it off. An arrival's result is registered as its dispatch state
// ends. A departure scans the lot through its memory one slot per cycle,
// comparing and compacting in the same pass; a ring head promotion may
// follow. busy_o drops in the cycle the result is shown, so the next
// transfer may start there. The user must write lot_capacity through
// cfg_we_i and cfg_data_i only while idle; the block does not enforce it. A
// zero, a value above the lot depth or one below the occupancy is ignored.
`default_nettype none

module slot_stack_with_overflow_queue #(
  parameter int unsigned LOT_DEPTH  = 16,
  parameter int unsigned RING_SLOTS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire ssq_pkg::req_t             req_i,
  output logic                           busy_o,
  output logic                           done_o,
  output ssq_pkg::res_t                  res_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [ssq_pkg::CAP_W-1:0] cfg_data_i
);

  import ssq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing
  ssq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // storage and arithmetic
  ssq_dp #(
    .LOT_DEPTH  (LOT_DEPTH),
    .RING_SLOTS (RING_SLOTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/ssq_ram.sv
// generic single write port ram with registered read
`default_nettype none

module ssq_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/ssq_ctrl.sv
// controller state machine sequencing arrivals, departure scans and promotion
`default_nettype none

module ssq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire ssq_pkg::dp_sts_t sts_i,
  output ssq_pkg::dp_cmd_t      cmd_o,
  output logic                  busy_o,
  output logic                  done_o
);

  import ssq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_PROMOTE
  } state_e;

  state_e  state_q, state_d;
  logic    done_q;
  dp_cmd_t cmd;

  // next state and datapath commands
  always_comb begin
    cmd        = '0;
    cmd.status = ST_PLACED;
    state_d    = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd.capture = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.func == FUNC_ARRIVE) begin
          cmd.finish = 1'b1;
          state_d    = S_IDLE;
          if (sts_i.lot_room) begin
            cmd.lot_push = 1'b1;
            cmd.status   = ST_PLACED;
          end else if (sts_i.ring_full) begin
            cmd.status = ST_REJECTED;
          end else begin
            cmd.ring_push = 1'b1;
            cmd.status    = ST_QUEUED;
          end
        end else if (sts_i.lot_empty) begin
          cmd.finish = 1'b1;
          cmd.status = ST_LOT_EMPTY;
          state_d    = S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts_i.scan_done) begin
          if (!sts_i.found) begin
            cmd.finish = 1'b1;
            cmd.status = ST_NOT_FOUND;
            state_d    = S_IDLE;
          end else if (sts_i.ring_empty) begin
            cmd.lot_drop = 1'b1;
            cmd.finish   = 1'b1;
            cmd.status   = ST_DEPARTED;
            state_d      = S_IDLE;
          end else begin
            cmd.lot_drop = 1'b1;
            state_d      = S_PROMOTE;
          end
        end
      end
      S_PROMOTE: begin
        cmd.promote  = 1'b1;
        cmd.finish   = 1'b1;
        cmd.status   = ST_DEPARTED;
        cmd.promoted = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd.finish;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  // result strobe is never held high
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |=> !done_q)
    else $error("result strobe held for two cycles");

  // an accepted transfer is always dispatched next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> (state_q == S_DISPATCH))
    else $error("accepted transfer not dispatched");

  // an entry is only removed after a key match
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.lot_drop |-> sts_i.found)
    else $error("lot entry dropped without a match");

endmodule

`default_nettype wire

FILE: rtl/core/ssq_dp.sv
// datapath: lot and ring memories, counters, scan pipeline and result register
`default_nettype none

module ssq_dp #(
  parameter int unsigned LOT_DEPTH  = 16,
  parameter int unsigned RING_SLOTS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ssq_pkg::req_t               req_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [ssq_pkg::CAP_W-1:0]   cfg_data_i,
  input  wire ssq_pkg::dp_cmd_t            cmd_i,
  output ssq_pkg::dp_sts_t                 sts_o,
  output ssq_pkg::res_t                    res_o
);

  import ssq_pkg::*;

  localparam int unsigned AW  = $clog2(LOT_DEPTH);
  localparam int unsigned CW  = $clog2(LOT_DEPTH + 1);
  localparam int unsigned RW  = $clog2(RING_SLOTS);
  localparam int unsigned EW  = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned LUW = (CW > LOT_USED_W) ? CW : LOT_USED_W;
  localparam int unsigned RUW = (RW > WAIT_USED_W) ? RW : WAIT_USED_W;

  function automatic logic [RW-1:0] ring_next(input logic [RW-1:0] p);
    logic [RW-1:0] n;
    if (p == RW'(RING_SLOTS - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  function automatic logic [RW-1:0] ring_used(input logic [RW-1:0] t,
                                              input logic [RW-1:0] h);
    logic [RW-1:0] u;
    if (t >= h) begin
      u = t - h;
    end else begin
      u = t + RW'(RING_SLOTS) - h;
    end
    return u;
  endfunction

  req_t          req_q;
  res_t          res_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cap_q;
  logic [RW-1:0] head_q, head_d;
  logic [RW-1:0] tail_q, tail_d;
  logic [CW-1:0] rd_ptr_q;
  logic          pend_q;
  logic [AW-1:0] pend_idx_q;
  logic          found_q;

  logic          issue;
  logic          match;
  logic          shift_we;
  logic          lot_we;
  logic [AW-1:0] lot_waddr;
  entry_t        lot_wdata;
  entry_t        lot_rdata;
  entry_t        ring_wdata;
  entry_t        ring_rdata;
  logic [EW-1:0] cfg_v;
  logic          cfg_ok;
  logic [LUW-1:0] lot_used_ext;
  logic [RUW-1:0] wait_used_ext;

  // scan pipeline: read one slot a cycle, compare the slot read the cycle before
  assign issue    = cmd_i.scan_en && (rd_ptr_q < count_q);
  assign match    = pend_q && !found_q && (lot_rdata.car_key == req_q.car_key);
  assign shift_we = cmd_i.scan_en && pend_q && found_q;

  // counter and pointer updates
  always_comb begin
    count_d = count_q;
    if (cmd_i.lot_push || cmd_i.promote) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.lot_drop) begin
      count_d = count_q - 1'b1;
    end
  end

  assign head_d = cmd_i.promote   ? ring_next(head_q) : head_q;
  assign tail_d = cmd_i.ring_push ? ring_next(tail_q) : tail_q;

  // lot write port: arrival, compaction shift or promotion
  assign lot_we    = cmd_i.lot_push || cmd_i.promote || shift_we;
  assign lot_waddr = shift_we ? (pend_idx_q - 1'b1) : count_q[AW-1:0];

  always_comb begin
    if (cmd_i.lot_push) begin
      lot_wdata.car_key   = req_q.car_key;
      lot_wdata.owner_tag = req_q.owner_tag;
    end else if (cmd_i.promote) begin
      lot_wdata = ring_rdata;
    end else begin
      lot_wdata = lot_rdata;
    end
  end

  assign ring_wdata.car_key   = req_q.car_key;
  assign ring_wdata.owner_tag = req_q.owner_tag;

  ssq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (LOT_DEPTH)
  ) u_lot_ram (
    .clk_i   (clk_i),
    .we_i    (lot_we),
    .waddr_i (lot_waddr),
    .wdata_i (lot_wdata),
    .raddr_i (rd_ptr_q[AW-1:0]),
    .rdata_o (lot_rdata)
  );

  // ring read port sits on the head, so its entry is ready for promotion
  ssq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (RING_SLOTS)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ring_push),
    .waddr_i (tail_q),
    .wdata_i (ring_wdata),
    .raddr_i (head_q),
    .rdata_o (ring_rdata)
  );

  // capacity write check
  assign cfg_v  = EW'(cfg_data_i);
  assign cfg_ok = (cfg_v != '0) && (cfg_v <= EW'(LOT_DEPTH)) && (cfg_v >= EW'(count_q));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cap_q    <= CW'(LOT_DEPTH);
      head_q   <= '0;
      tail_q   <= '0;
      rd_ptr_q <= '0;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      if (cfg_we_i && cfg_ok) begin
        cap_q <= CW'(cfg_v);
      end
      if (cmd_i.scan_start) begin
        rd_ptr_q <= '0;
        pend_q   <= 1'b0;
        found_q  <= 1'b0;
      end else if (cmd_i.scan_en) begin
        if (issue) begin
          rd_ptr_q <= rd_ptr_q + 1'b1;
        end
        pend_q <= issue;
        if (match) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  assign lot_used_ext  = LUW'(count_d);
  assign wait_used_ext = RUW'(ring_used(tail_d, head_d));

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.scan_en) begin
      pend_idx_q <= rd_ptr_q[AW-1:0];
    end
    if (cmd_i.finish) begin
      res_q.status    <= cmd_i.status;
      res_q.promoted  <= cmd_i.promoted;
      res_q.lot_used  <= lot_used_ext[LOT_USED_W-1:0];
      res_q.wait_used <= wait_used_ext[WAIT_USED_W-1:0];
    end
  end

  // status to the controller
  assign sts_o.func       = req_q.func;
  assign sts_o.lot_room   = (count_q < cap_q) && (count_q < CW'(LOT_DEPTH));
  assign sts_o.ring_full  = (ring_next(tail_q) == head_q);
  assign sts_o.lot_empty  = (count_q == '0);
  assign sts_o.ring_empty = (head_q == tail_q);
  assign sts_o.scan_done  = !issue && !pend_q;
  assign sts_o.found      = found_q;

  assign res_o = res_q;

  // occupancy never passes the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= cap_q)
    else $error("lot occupancy above capacity");

  // a compaction shift never targets below slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni) shift_we |-> (pend_idx_q != '0))
    else $error("compaction shift from slot zero");

endmodule

`default_nettype wire

FILE: verif/ssq_checker.sv
// result checker of the parking lot stack with overflow ring
`timescale 1ns / 1ps

module ssq_checker #(
  parameter int unsigned LOT_DEPTH  = 16,
  parameter int unsigned RING_SLOTS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  ssq_pkg::req_t             req_i,
  input  logic                      done_i,
  input  ssq_pkg::res_t             res_i,
  input  logic                      cfg_we_i,
  input  logic [ssq_pkg::CAP_W-1:0] cfg_data_i,
  output int                        pending_o,
  output int                        fail_count_o
);

  import ssq_pkg::*;

  // shadow copy of the lot, the waiting ring and the capacity register
  entry_t lot_mem  [LOT_DEPTH];
  entry_t ring_mem [RING_SLOTS];
  int     lot_cnt;
  int     ring_rd;
  int     ring_wr;
  int     capacity;
  int     errors;
  res_t   outcome_q [$];

  // capacity writes out of range or below occupancy leave the register alone
  function automatic void apply_capacity_write(logic [CAP_W-1:0] value);
    if (value != 0 && value <= LOT_DEPTH && value >= lot_cnt) begin
      capacity = int'(value);
    end
  endfunction

  // outcome of one request, updating the shadow state
  function automatic res_t predict_parking_outcome(req_t req);
    res_t outcome;
    int   pos;
    int   i;
    outcome.promoted = 1'b0;
    if (req.func == FUNC_ARRIVE) begin
      if (lot_cnt < capacity && lot_cnt < LOT_DEPTH) begin
        lot_mem[lot_cnt].car_key   = req.car_key;
        lot_mem[lot_cnt].owner_tag = req.owner_tag;
        lot_cnt++;
        outcome.status = ST_PLACED;
      end else if ((ring_wr + 1) % RING_SLOTS == ring_rd) begin
        outcome.status = ST_REJECTED;
      end else begin
        ring_mem[ring_wr].car_key   = req.car_key;
        ring_mem[ring_wr].owner_tag = req.owner_tag;
        ring_wr = (ring_wr + 1) % RING_SLOTS;
        outcome.status = ST_QUEUED;
      end
    end else if (lot_cnt == 0) begin
      outcome.status = ST_LOT_EMPTY;
    end else begin
      // oldest matching entry wins
      pos = lot_cnt;
      for (i = 0; i < lot_cnt && pos == lot_cnt; i++) begin
        if (lot_mem[i].car_key == req.car_key) pos = i;
      end
      if (pos == lot_cnt) begin
        outcome.status = ST_NOT_FOUND;
      end else begin
        // close the gap, keeping the order of younger entries
        for (i = pos; i + 1 < lot_cnt; i++) begin
          lot_mem[i] = lot_mem[i + 1];
        end
        lot_cnt--;
        outcome.status = ST_DEPARTED;
        // ring head moves onto the lot
        if (ring_rd != ring_wr) begin
          lot_mem[lot_cnt] = ring_mem[ring_rd];
          lot_cnt++;
          ring_rd = (ring_rd + 1) % RING_SLOTS;
          outcome.promoted = 1'b1;
        end
      end
    end
    outcome.lot_used  = LOT_USED_W'(lot_cnt);
    outcome.wait_used = WAIT_USED_W'((ring_wr + RING_SLOTS - ring_rd) % RING_SLOTS);
    return outcome;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // watch result, configuration and request transfers at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      outcome_q.delete();
      lot_cnt      = 0;
      ring_rd      = 0;
      ring_wr      = 0;
      capacity     = LOT_DEPTH;
      errors       = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // result transfer against the oldest outstanding outcome
      if (done_i) begin
        if (outcome_q.size() == 0) begin
          $error("result with no request outstanding: status %0d", res_i.status);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          check_field("status", want.status, res_i.status);
          check_field("promoted", want.promoted, res_i.promoted);
          check_field("lot_used", want.lot_used, res_i.lot_used);
          check_field("wait_used", want.wait_used, res_i.wait_used);
        end
      end
      if (cfg_we_i) apply_capacity_write(cfg_data_i);
      if (start_i && !busy_i) outcome_q.push_back(predict_parking_outcome(req_i));
      pending_o    <= outcome_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

FILE: verif/slot_stack_with_overflow_queue_tb.sv
// stimulus and verdict for the parking lot stack with overflow ring
`timescale 1ns / 1ps

module slot_stack_with_overflow_queue_tb;
  import ssq_pkg::*;

  localparam logic FUNC_DEPART     = ~FUNC_ARRIVE;
  localparam int   POOL_SIZE       = 32;
  localparam int   PHASES          = 10;
  localparam int   ITEMS_PER_PHASE = 130;
  localparam int   CYCLE_LIMIT     = 400000;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             start_i    = 1'b0;
  req_t             req_i      = '0;
  logic             cfg_we_i   = 1'b0;
  logic [CAP_W-1:0] cfg_data_i = '0;
  logic             busy_o;
  logic             done_o;
  res_t             res_o;
  int               pending;
  int               fail_count;
  int               cycles     = 0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int               pool_span;
  int               gap_max;
  int               arrive_pct;
  logic [CAP_W-1:0] cap_value;

  slot_stack_with_overflow_queue u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  ssq_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .req_i        (req_i),
    .done_i       (done_o),
    .res_i        (res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // keys mostly from a small pool so departures find their cars
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(0, pool_span - 1)];
  endfunction

  // one request transfer after a random gap; start stays high if no gap
  task automatic offer_request(input logic func, input logic [KEY_W-1:0] key,
                               input logic [TAG_W-1:0] owner);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    req_i.func      <= func;
    req_i.car_key   <= key;
    req_i.owner_tag <= owner;
    do @(posedge clk_i); while (busy_o);
  endtask

  // hold off until every outstanding result has been seen
  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    cfg_data_i <= value;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    pool_span   = POOL_SIZE;
    gap_max     = 5;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty lot, key extremes, missing key, duplicate keys
    offer_request(FUNC_DEPART, key_pool[2], '0);
    offer_request(FUNC_ARRIVE, '0, '1);
    offer_request(FUNC_ARRIVE, '1, '0);
    offer_request(FUNC_ARRIVE, '0, {$urandom, $urandom});
    offer_request(FUNC_DEPART, key_pool[3], '1);
    offer_request(FUNC_DEPART, '0, '0);
    drain_results();

    // capacity writes that must be ignored, then a tiny lot
    set_capacity('0);
    set_capacity(5'd1);
    set_capacity(5'd17);
    set_capacity('1);
    set_capacity(5'd2);

    // fill the ring until it rejects, then promote its head
    repeat (16) offer_request(FUNC_ARRIVE, pick_key(), {$urandom, $urandom});
    offer_request(FUNC_DEPART, '1, '0);
    drain_results();

    // ring holds entries while the lot has room again
    set_capacity(5'd16);
    offer_request(FUNC_ARRIVE, key_pool[4], '1);
    offer_request(FUNC_DEPART, '0, '1);

    // random phases, capacity changed while idle in between
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase % 5)
        0:       cap_value = 5'd1;
        1:       cap_value = 5'd16;
        2:       cap_value = 5'($urandom_range(0, 31));
        3:       cap_value = 5'($urandom_range(2, 15));
        default: cap_value = (phase % 2 == 0) ? 5'd0 : 5'd31;
      endcase
      set_capacity(cap_value);
      gap_max    = (phase % 3 == 1) ? 0 : 5;
      arrive_pct = $urandom_range(35, 70);
      pool_span  = $urandom_range(4, POOL_SIZE);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < arrive_pct) begin
          offer_request(FUNC_ARRIVE, pick_key(), {$urandom, $urandom});
        end else begin
          offer_request(FUNC_DEPART, pick_key(), {$urandom, $urandom});
        end
        if ($urandom_range(0, 63) == 0) drain_results();
      end
    end

    drain_results();
    repeat (30) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ssq_pkg.sv
rtl/core/ssq_ram.sv
rtl/core/ssq_ctrl.sv
rtl/core/ssq_dp.sv
rtl/core/slot_stack_with_overflow_queue.sv
verif/ssq_checker.sv
verif/slot_stack_with_overflow_queue_tb.sv
